[hw/rtl/poisson_likelihood_accumulator_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the likelihood accumulator
// Short forms for same-cycle and next-cycle implications on clk_i.
// ----------------------------------------------------------------------------
`ifndef POISSON_LIKELIHOOD_ACCUMULATOR_CORE_MACROS_SVH
`define POISSON_LIKELIHOOD_ACCUMULATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/plac_pkg.sv]
// ----------------------------------------------------------------------------
// plac_pkg
// Shared types and constants of the Poisson likelihood accumulator.
// ----------------------------------------------------------------------------
package plac_pkg;

  // Fraction bits of the count format.
  localparam int FracBits = 16;
  // Fraction bits of the logarithm.
  localparam int LogFrac  = 24;
  // Squaring iterations of the logarithm, one result bit each.
  localparam int SqIters  = LogFrac;
  // ln(2) in Q0.32.
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  localparam int SumW  = 48;
  localparam int TermW = 41;
  localparam int AccW  = 50;

  // Configuration register indexes.
  localparam logic [2:0] CfgCutEnable  = 3'd0;
  localparam logic [2:0] CfgEUpperCut  = 3'd1;
  localparam logic [2:0] CfgELowerCut  = 3'd2;
  localparam logic [2:0] CfgMuLowerCut = 3'd3;
  localparam logic [2:0] CfgCountFloor = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQ,
    ST_SQ_END,
    ST_LN,
    ST_LN_W,
    ST_DL,
    ST_DL_W,
    ST_ACC
  } plac_state_e;

endpackage

[hw/rtl/plac_if.sv]
// ----------------------------------------------------------------------------
// plac interfaces
// Valid/ready channels for bin requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface plac_item_if;
  logic        valid;
  logic        ready;
  logic        sample_kind;
  logic [15:0] bin_energy;
  logic [31:0] data_count;
  logic [31:0] pred_count;
  logic        last_bin;
  modport source (output valid, sample_kind, bin_energy, data_count, pred_count,
                  last_bin, input ready);
  modport sink   (input valid, sample_kind, bin_energy, data_count, pred_count,
                  last_bin, output ready);
endinterface

interface plac_result_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] log_likelihood;
  logic               saturated;
  modport source (output valid, log_likelihood, saturated, input ready);
  modport sink   (input valid, log_likelihood, saturated, output ready);
endinterface

interface plac_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/plac_mul.sv]
// ----------------------------------------------------------------------------
// plac_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module plac_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);
  import plac_pkg::*;

  logic [63:0] prod_q;

  // The product is registered every cycle; the sequencer picks when to use it.
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(a_i) * 64'(b_i);
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/poisson_likelihood_accumulator_core.sv]
// ----------------------------------------------------------------------------
// poisson_likelihood_accumulator_core
// Accumulates the Poisson -2 log likelihood ratio over a stream of bins.
// ----------------------------------------------------------------------------
// One bin request is taken at a time. A skipped or empty bin goes from the
// accept cycle straight to the accumulate step. A bin with both counts above
// the floor runs the accept cycle, then for each of the two logarithms a
// 5-step normalize, repeated squaring on the single shared 32x32 multiplier
// and a step to take the last bit, then two multiplies with a wait state each
// for the ln(2) scaling and the count product, and the accumulate step. A
// result waits in an output register; if a previous result has not been
// taken, the last bin holds in the accumulate step until it is.
`include "poisson_likelihood_accumulator_core_macros.svh"

module poisson_likelihood_accumulator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  plac_item_if.sink     in_if,
  plac_result_if.source out_if,
  plac_cfg_if.sink      cfg_if
);
  import plac_pkg::*;

  // Configuration registers.
  logic        cut_enable_q;
  logic [15:0] e_upper_cut_q, e_lower_cut_q, mu_lower_cut_q;
  logic [31:0] count_floor_q;

  // Control state.
  plac_state_e state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        pass_q, pass_d;
  logic        last_q, last_d;
  logic        add_q, add_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic        ovf_q, ovf_d;
  logic        out_valid_q, out_valid_d;

  // Datapath.
  logic [31:0] d_q, d_d, p_q, p_d;
  logic [31:0] m_q, m_d;
  logic [4:0]  k_q, k_d;
  logic [LogFrac-2:0] frac_q, frac_d;
  logic signed [30:0] logd_q, logd_d;
  logic        neg_q, neg_d;
  logic [31:0] mag_q, mag_d;
  logic [31:0] lnmag_q, lnmag_d;
  logic signed [TermW-1:0] term_q, term_d;
  logic signed [SumW-1:0]  out_sum_q, out_sum_d;
  logic        out_sat_q, out_sat_d;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] m_next;

  plac_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Configuration writes are always taken.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_enable_q   <= 1'b1;
      e_upper_cut_q  <= 16'd4915;
      e_lower_cut_q  <= 16'd410;
      mu_lower_cut_q <= 16'd819;
      count_floor_q  <= 32'd0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CfgCutEnable:  cut_enable_q   <= cfg_if.data[0];
        CfgEUpperCut:  e_upper_cut_q  <= cfg_if.data[15:0];
        CfgELowerCut:  e_lower_cut_q  <= cfg_if.data[15:0];
        CfgMuLowerCut: mu_lower_cut_q <= cfg_if.data[15:0];
        CfgCountFloor: count_floor_q  <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Squared mantissa renormalized to Q1.31; top product bit is the log bit.
  assign m_next = prod[63] ? prod[63:32] : prod[62:31];

  // Intermediate values of the sequencer.
  logic        keep, d_full, p_full;
  logic [4:0]  sh;
  logic        top_zero;
  logic signed [6:0]  lexp;
  logic signed [30:0] logval;
  logic signed [31:0] diff;
  logic [63:0] ln_round, dl_round;
  logic [37:0] r_mag;
  logic signed [TermW-1:0] dl2, pd2;
  logic signed [AccW-1:0]  acc;
  logic signed [SumW-1:0]  acc_sat;
  logic        acc_ovf;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    pass_d      = pass_q;
    last_d      = last_q;
    add_d       = add_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    d_d         = d_q;
    p_d         = p_q;
    m_d         = m_q;
    k_d         = k_q;
    frac_d      = frac_q;
    logd_d      = logd_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    lnmag_d     = lnmag_q;
    term_d      = term_q;
    out_sum_d   = out_sum_q;
    out_sat_d   = out_sat_q;
    mul_a       = m_q;
    mul_b       = m_q;

    // Energy window and count classification of the incoming request.
    if (in_if.sample_kind == 1'b0) begin
      keep = !((cut_enable_q && (in_if.bin_energy > e_upper_cut_q)) ||
               (in_if.bin_energy < e_lower_cut_q));
    end else begin
      keep = in_if.bin_energy >= mu_lower_cut_q;
    end
    d_full = in_if.data_count > count_floor_q;
    p_full = in_if.pred_count > count_floor_q;

    // Binary-search normalize, one shift width per step.
    unique case (step_q)
      3'd0:    sh = 5'd16;
      3'd1:    sh = 5'd8;
      3'd2:    sh = 5'd4;
      3'd3:    sh = 5'd2;
      default: sh = 5'd1;
    endcase
    top_zero = (m_q >> (6'd32 - 6'(sh))) == 32'd0;

    // Logarithm in Q.24 from exponent and the collected fraction bits.
    lexp   = $signed({2'b00, k_q}) - 7'(FracBits);
    logval = {lexp, frac_q, prod[63]};
    diff   = 32'(logd_q) - 32'(logval);

    ln_round = prod + 64'h8000_0000;
    dl_round = prod + (64'd1 << (LogFrac - 1));
    r_mag    = dl_round[LogFrac+37:LogFrac];
    dl2      = neg_q ? -$signed({2'b00, r_mag, 1'b0}) : $signed({2'b00, r_mag, 1'b0});
    pd2      = $signed({8'd0, p_q, 1'b0}) - $signed({8'd0, d_q, 1'b0});

    // Saturating accumulate.
    acc     = AccW'(sum_q) + AccW'(term_q);
    acc_ovf = 1'b0;
    if (acc > AccW'(48'sh7FFF_FFFF_FFFF)) begin
      acc_sat = 48'sh7FFF_FFFF_FFFF;
      acc_ovf = 1'b1;
    end else if (acc < -AccW'(49'sh0_8000_0000_0000)) begin
      acc_sat = 48'sh8000_0000_0000;
      acc_ovf = 1'b1;
    end else begin
      acc_sat = acc[SumW-1:0];
    end

    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          d_d    = in_if.data_count;
          p_d    = in_if.pred_count;
          last_d = in_if.last_bin;
          m_d    = in_if.data_count;
          k_d    = 5'd31;
          step_d = 3'd0;
          pass_d = 1'b0;
          add_d  = keep && (!d_full || p_full);
          term_d = $signed({8'd0, in_if.pred_count, 1'b0});
          if (keep && d_full && p_full) begin
            state_d = ST_NORM;
          end else begin
            state_d = ST_ACC;
          end
        end
      end
      ST_NORM: begin
        if (top_zero) begin
          m_d = m_q << sh;
          k_d = k_q - sh;
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) begin
          cnt_d   = 5'd0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        if (cnt_q != 5'd0) begin
          mul_a  = m_next;
          mul_b  = m_next;
          frac_d = {frac_q[LogFrac-3:0], prod[63]};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(SqIters - 1)) begin
          state_d = ST_SQ_END;
        end
      end
      ST_SQ_END: begin
        if (!pass_q) begin
          logd_d  = logval;
          m_d     = p_q;
          k_d     = 5'd31;
          step_d  = 3'd0;
          pass_d  = 1'b1;
          state_d = ST_NORM;
        end else begin
          neg_d   = diff[31];
          mag_d   = diff[31] ? 32'(-diff) : 32'(diff);
          state_d = ST_LN;
        end
      end
      ST_LN: begin
        mul_a   = mag_q;
        mul_b   = Ln2Q32;
        state_d = ST_LN_W;
      end
      ST_LN_W: begin
        lnmag_d = ln_round[63:32];
        state_d = ST_DL;
      end
      ST_DL: begin
        mul_a   = d_q;
        mul_b   = lnmag_q;
        state_d = ST_DL_W;
      end
      ST_DL_W: begin
        term_d  = pd2 + dl2;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (!last_q) begin
          if (add_q) begin
            sum_d = acc_sat;
            ovf_d = ovf_q | acc_ovf;
          end
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_if.ready) begin
          out_sum_d   = add_q ? acc_sat : sum_q;
          out_sat_d   = ovf_q | (add_q & acc_ovf);
          out_valid_d = 1'b1;
          sum_d       = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      pass_q      <= 1'b0;
      last_q      <= 1'b0;
      add_q       <= 1'b0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      pass_q      <= pass_d;
      last_q      <= last_d;
      add_q       <= add_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    d_q       <= d_d;
    p_q       <= p_d;
    m_q       <= m_d;
    k_q       <= k_d;
    frac_q    <= frac_d;
    logd_q    <= logd_d;
    neg_q     <= neg_d;
    mag_q     <= mag_d;
    lnmag_q   <= lnmag_d;
    term_q    <= term_d;
    out_sum_q <= out_sum_d;
    out_sat_q <= out_sat_d;
  end

  assign in_if.ready           = (state_q == ST_IDLE);
  assign out_if.valid          = out_valid_q;
  assign out_if.log_likelihood = out_sum_q;
  assign out_if.saturated      = out_sat_q;

  // Checks on the sequencer.
  `PLAC_ASSERT_NOW(a_sq_count, state_q == ST_SQ, cnt_q < 5'(SqIters), "square count overrun")
  `PLAC_ASSERT_NEXT(a_accept_busy, in_if.valid && in_if.ready, state_q != ST_IDLE, "accept left idle")
  `PLAC_ASSERT_NEXT(a_last_emits, state_q == ST_ACC && last_q && (!out_valid_q || out_if.ready), out_valid_q && sum_q == '0 && !ovf_q, "last bin did not emit and clear")
  `PLAC_ASSERT_NEXT(a_norm_len, state_q == ST_NORM && step_q == 3'd4, state_q == ST_SQ && cnt_q == 5'd0, "normalize did not hand over")

endmodule
